>>> hw/rtl/gss_pkg.sv
// shared types, constants and helpers for the gaussian blur and sobel gradient block
`timescale 1ns / 1ps
package gss_pkg;

	// field widths
	localparam int PIX_W        = 8;
	localparam int GRAD_W       = 11;
	localparam int MAG_W        = 15;
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;

	// frame geometry
	localparam int FH_W         = 13;
	localparam int ROW_W        = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int RAW_ROWS     = 8;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	// parameter defaults
	localparam int DEF_MAX_WIDTH     = 2048;
	localparam int DEF_MAG_FRAC_BITS = 4;

	// blur arithmetic: divide by 159 as multiply by rounded-up reciprocal
	localparam int ACC_W     = 16;
	localparam int WGT_W     = 4;
	localparam int DIV_SHIFT = 31;
	localparam int DIV_MUL_W = 24;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 24'd13506187;
	localparam int PROD_W    = ACC_W + DIV_MUL_W;

	// squared gradient width before fraction bits
	localparam int GRAD_SQ_W = 21;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	// tap sequence limits
	localparam logic [2:0] TAP_LAST_M  = 3'd4;
	localparam logic [1:0] TAP_LAST_P  = 2'd2;
	localparam logic [3:0] TAP_PIDX_LAST = 4'd8;
	localparam int         BLUR_CNT    = 9;

	// tag carried along with each tap read
	typedef struct packed {
		logic             first;
		logic             last;
		logic [3:0]       pidx;
		logic [WGT_W-1:0] weight;
	} tap_info_t;

	// 5x5 gaussian kernel weight, symmetric in both axes
	function automatic logic [WGT_W-1:0] gauss_weight(input logic [2:0] i, input logic [2:0] j);
		logic [1:0] a;
		logic [1:0] b;
		logic [WGT_W-1:0] w;
		a = (i > 3'd2) ? 2'(3'd4 - i) : 2'(i);
		b = (j > 3'd2) ? 2'(3'd4 - j) : 2'(j);
		case ({a, b})
			4'b0000: w = 4'd2;
			4'b0001: w = 4'd4;
			4'b0010: w = 4'd5;
			4'b0100: w = 4'd4;
			4'b0101: w = 4'd9;
			4'b0110: w = 4'd12;
			4'b1000: w = 4'd5;
			4'b1001: w = 4'd12;
			4'b1010: w = 4'd15;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/gss_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module gss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read before write port, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> hw/rtl/gss_tap_gen.sv
// raw pixel tap sequencer: 3x3 blur points times 5x5 kernel taps into ring addresses
`timescale 1ns / 1ps
module gss_tap_gen #(
	parameter int MAX_WIDTH = gss_pkg::DEF_MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [gss_pkg::ROW_W-1:0]             out_row,
	input  logic [$clog2(MAX_WIDTH)-1:0]          out_col,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]        fw,
	input  logic [gss_pkg::FH_W-1:0]              fh,
	input  logic [$clog2(gss_pkg::RAW_ROWS*MAX_WIDTH)-1:0] base_addr,
	output logic                                  busy,
	output logic                                  rd_en,
	output logic [$clog2(gss_pkg::RAW_ROWS*MAX_WIDTH)-1:0] rd_addr,
	output gss_pkg::tap_info_t                    rd_info
);
	import gss_pkg::*;

	localparam int FW_W = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = RAW_ROWS * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = ((FW_W > FH_W) ? FW_W : FH_W) + 2;
	localparam int DW = FW_W + 4;
	localparam int SW = AW + 2;

	function automatic logic signed [CW-1:0] clampc(input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] hi);
		logic signed [CW-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic       active_q;
	logic [1:0] pr_q, pc_q;
	logic [2:0] mr_q, mc_q;
	logic       vld_s1, vld_s2, rd_en_q;

	logic signed [3:0] dy_s1, dx_s1;
	tap_info_t         info_s1, info_s2, info_s3;
	logic signed [DW-1:0] delta_s2;
	logic [AW-1:0]     rd_addr_q;

	logic signed [CW-1:0] r_s, c_s, hi_y, hi_x, y1, x1, y2, x2;
	logic signed [SW-1:0] sum, adj;
	tap_info_t            info_c;

	// clamped tap coordinates relative to the output pixel
	always_comb begin
		r_s  = $signed(CW'(out_row));
		c_s  = $signed(CW'(out_col));
		hi_y = $signed(CW'(fh)) - CW'(1);
		hi_x = $signed(CW'(fw)) - CW'(1);
		y1   = clampc(r_s + $signed(CW'(pr_q)) - CW'(1), hi_y);
		x1   = clampc(c_s + $signed(CW'(pc_q)) - CW'(1), hi_x);
		y2   = clampc(y1 + $signed(CW'(mr_q)) - CW'(2), hi_y);
		x2   = clampc(x1 + $signed(CW'(mc_q)) - CW'(2), hi_x);
		info_c.first  = (mr_q == 3'd0) && (mc_q == 3'd0);
		info_c.last   = (mr_q == TAP_LAST_M) && (mc_q == TAP_LAST_M);
		info_c.pidx   = 4'(pr_q) * 4'd3 + 4'(pc_q);
		info_c.weight = gauss_weight(mr_q, mc_q);
	end

	// ring address with wrap
	always_comb begin
		sum = $signed(SW'(base_addr)) + SW'(delta_s2);
		if (sum < 0) begin
			adj = sum + SW'(DEPTH);
		end else if (sum >= DEPTH) begin
			adj = sum - SW'(DEPTH);
		end else begin
			adj = sum;
		end
	end

	// tap counters and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pr_q     <= '0;
			pc_q     <= '0;
			mr_q     <= '0;
			mc_q     <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			rd_en_q  <= 1'b0;
		end else begin
			vld_s1  <= active_q;
			vld_s2  <= vld_s1;
			rd_en_q <= vld_s2;
			if (start) begin
				active_q <= 1'b1;
				pr_q     <= '0;
				pc_q     <= '0;
				mr_q     <= '0;
				mc_q     <= '0;
			end else if (active_q) begin
				if (mc_q == TAP_LAST_M) begin
					mc_q <= '0;
					if (mr_q == TAP_LAST_M) begin
						mr_q <= '0;
						if (pc_q == TAP_LAST_P) begin
							pc_q <= '0;
							if (pr_q == TAP_LAST_P) begin
								pr_q     <= '0;
								active_q <= 1'b0;
							end else begin
								pr_q <= pr_q + 2'd1;
							end
						end else begin
							pc_q <= pc_q + 2'd1;
						end
					end else begin
						mr_q <= mr_q + 3'd1;
					end
				end else begin
					mc_q <= mc_q + 3'd1;
				end
			end
		end
	end

	// offset, delta and address stages
	always_ff @(posedge clk) begin
		dy_s1     <= 4'(y2 - r_s);
		dx_s1     <= 4'(x2 - c_s);
		info_s1   <= info_c;
		delta_s2  <= DW'(dy_s1) * $signed(DW'(fw)) + DW'(dx_s1);
		info_s2   <= info_s1;
		rd_addr_q <= AW'(adj);
		info_s3   <= info_s2;
	end

	assign busy    = active_q | vld_s1 | vld_s2 | rd_en_q;
	assign rd_en   = rd_en_q;
	assign rd_addr = rd_addr_q;
	assign rd_info = info_s3;

endmodule

>>> hw/rtl/gss_sqrt.sv
// iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module gss_sqrt #(
	parameter int IN_W = 29
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [IN_W-1:0]         radicand,
	output logic                    done,
	output logic [(IN_W+1)/2-1:0]   root
);

	localparam int OUT_W = (IN_W + 1) / 2;
	localparam int EW = 2 * OUT_W;
	localparam int CNT_W = $clog2(OUT_W + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EW-1:0]    x_q;
	logic [OUT_W:0]   rem_q;
	logic [OUT_W-1:0] root_q;

	logic [OUT_W+2:0] rem_sh, trial;
	logic             ge;

	// one restoring step
	always_comb begin
		rem_sh = {rem_q, x_q[EW-1:EW-2]};
		trial  = (OUT_W+3)'({root_q, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(OUT_W);
				x_q    <= EW'(radicand);
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				x_q <= {x_q[EW-3:0], 2'b00};
				if (ge) begin
					rem_q  <= (OUT_W+1)'(rem_sh - trial);
					root_q <= {root_q[OUT_W-2:0], 1'b1};
				end else begin
					rem_q  <= (OUT_W+1)'(rem_sh);
					root_q <= {root_q[OUT_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hw/rtl/gauss5_sobel_gradient.sv
// top level: gaussian 5x5 blur then sobel 3x3 gradient on a raster pixel stream
//
//  channel  direction  handshake               payload
//  px       in         px_valid / px_ready     action, pixel
//  res      out        res_valid / res_ready   grad_x, grad_y, magnitude, frame_last
//  cfg      in         cfg_we (no wait)        cfg_index, cfg_data
//
// an item that gives no result leaves the block idle; an item that gives a result holds off the next
// acceptance until its blur, sobel, square, root and emit states are through; the blur is bound by
// the single read port of the raw line ring: one kernel tap is read per cycle.
// results trail the input by 3*width+3 items; drain items flush the rest of a frame.
// reset clears all counters; the ring needs no clearing since only written entries are read.
// px_ready stays low while a result is computed or waits for the res slot to free.
`timescale 1ns / 1ps
module gauss5_sobel_gradient #(
	parameter int MAX_WIDTH     = gss_pkg::DEF_MAX_WIDTH,
	parameter int MAG_FRAC_BITS = gss_pkg::DEF_MAG_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gss_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                px_valid,
	output logic                                px_ready,
	input  logic                                action,
	input  logic [gss_pkg::PIX_W-1:0]           pixel,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [gss_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [gss_pkg::GRAD_W-1:0]   grad_y,
	output logic [gss_pkg::MAG_W-1:0]           magnitude,
	output logic                                frame_last
);
	import gss_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int FW_W  = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = RAW_ROWS * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int POS_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
	localparam int SQ_W  = GRAD_SQ_W + 2 * MAG_FRAC_BITS;
	localparam int ROOT_W = (SQ_W + 1) / 2;
	localparam int RESET_FW = (MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BLUR,
		ST_SOBEL,
		ST_SQUARE,
		ST_ROOT,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [POS_W-1:0] lead_q, in_pos_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [FH_W-1:0]  in_row_q;
	logic [ROW_W-1:0] out_row_q;
	logic [AW-1:0]    in_addr_q, out_addr_q;

	logic signed [GRAD_W-1:0] gx_q, gy_q;

	// tap and blur datapath
	logic             tap_busy, rd_en;
	logic [AW-1:0]    rd_addr, ram_addr;
	tap_info_t        rd_info, info_s4;
	logic             vld_s4, blur_vld_s5;
	logic [3:0]       pidx_s5;
	logic [PIX_W-1:0] rd_data;
	logic [ACC_W-1:0] acc_q;
	logic [PIX_W-1:0] p_q [BLUR_CNT];
	logic [PIX_W+WGT_W-1:0] tap_prod;
	logic [PROD_W-1:0] div_prod;
	logic              blur_done;

	// control decode
	logic px_acc, start_frame, in_frame, push, gen, ram_we, slot_free;
	logic [FW_W-1:0]  fw_new, fw_eff, col_inc, ocol_inc;
	logic [FH_W-1:0]  fh_new, orow_next;
	logic [POS_W-1:0] lead_new;
	logic             col_wrap, ocol_wrap, frame_end;
	logic signed [GRAD_W-1:0] gx_c, gy_c;
	logic signed [2*GRAD_W-1:0] sq_full;
	logic [SQ_W-1:0]  radicand;
	logic             root_start, root_done;
	logic [ROOT_W-1:0] root;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(RESET_WIDTH);
			height_q <= HEIGHT_REG_W'(RESET_HEIGHT);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame size clamp and input decode
	always_comb begin
		if (width_q == '0) begin
			fw_new = FW_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			fw_new = FW_W'(MAX_WIDTH);
		end else begin
			fw_new = FW_W'(width_q);
		end
		if (height_q == '0) begin
			fh_new = FH_W'(1);
		end else if (32'(height_q) > HEIGHT_LIMIT) begin
			fh_new = FH_W'(HEIGHT_LIMIT);
		end else begin
			fh_new = FH_W'(height_q);
		end
		lead_new    = POS_W'(fw_new) + POS_W'({fw_new, 1'b0}) + POS_W'(3);
		px_ready    = (state_q == ST_IDLE);
		px_acc      = px_valid && px_ready;
		start_frame = !action && (in_pos_q == '0) && (out_row_q == '0) && (out_col_q == '0);
		fw_eff      = start_frame ? fw_new : fw_q;
		in_frame    = in_row_q < fh_q;
		push        = in_frame && !action;
		gen         = in_frame ? (push && (in_pos_q >= lead_q)) : 1'b1;
		col_inc     = FW_W'(in_col_q) + FW_W'(1);
		col_wrap    = col_inc >= fw_eff;
		ram_we      = px_acc && push;
		ram_addr    = ram_we ? in_addr_q : rd_addr;
		ocol_inc    = FW_W'(out_col_q) + FW_W'(1);
		ocol_wrap   = ocol_inc >= fw_q;
		orow_next   = FH_W'(out_row_q) + FH_W'(ocol_wrap);
		frame_end   = orow_next >= fh_q;
		slot_free   = !res_valid || res_ready;
	end

	gss_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_raw_ring (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(pixel),
		.rdata(rd_data)
	);

	gss_tap_gen #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_tap_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (px_acc && gen),
		.out_row  (out_row_q),
		.out_col  (out_col_q),
		.fw       (fw_q),
		.fh       (fh_q),
		.base_addr(out_addr_q),
		.busy     (tap_busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_info  (rd_info)
	);

	// tap valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4      <= 1'b0;
			blur_vld_s5 <= 1'b0;
		end else begin
			vld_s4      <= rd_en;
			blur_vld_s5 <= vld_s4 && info_s4.last;
		end
	end

	assign tap_prod  = rd_data * info_s4.weight;
	assign div_prod  = PROD_W'(acc_q) * PROD_W'(DIV_MUL);
	assign blur_done = blur_vld_s5 && (pidx_s5 == TAP_PIDX_LAST);

	// kernel accumulate, divide by 159, store blurred neighbor
	always_ff @(posedge clk) begin
		info_s4 <= rd_info;
		pidx_s5 <= info_s4.pidx;
		if (vld_s4) begin
			acc_q <= info_s4.first ? ACC_W'(tap_prod) : acc_q + ACC_W'(tap_prod);
		end
		if (blur_vld_s5) begin
			p_q[pidx_s5] <= PIX_W'(div_prod >> DIV_SHIFT);
		end
	end

	// sobel on the 3x3 blurred neighborhood, then the sum of squares for the root
	always_comb begin
		gx_c = ($signed(GRAD_W'(p_q[2])) - $signed(GRAD_W'(p_q[0])))
			+ GRAD_W'(2) * ($signed(GRAD_W'(p_q[5])) - $signed(GRAD_W'(p_q[3])))
			+ ($signed(GRAD_W'(p_q[8])) - $signed(GRAD_W'(p_q[6])));
		gy_c = ($signed(GRAD_W'(p_q[6])) - $signed(GRAD_W'(p_q[0])))
			+ GRAD_W'(2) * ($signed(GRAD_W'(p_q[7])) - $signed(GRAD_W'(p_q[1])))
			+ ($signed(GRAD_W'(p_q[8])) - $signed(GRAD_W'(p_q[2])));
		sq_full    = gx_q * gx_q + gy_q * gy_q;
		radicand   = SQ_W'(sq_full[GRAD_SQ_W-1:0]) << (2 * MAG_FRAC_BITS);
		root_start = (state_q == ST_SQUARE);
	end

	gss_sqrt #(
		.IN_W(SQ_W)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(radicand),
		.done    (root_done),
		.root    (root)
	);

	// sequencer, frame counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fw_q       <= FW_W'(RESET_FW);
			fh_q       <= FH_W'(RESET_HEIGHT);
			lead_q     <= POS_W'(3 * RESET_FW + 3);
			in_pos_q   <= '0;
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_addr_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_addr_q <= '0;
			gx_q       <= '0;
			gy_q       <= '0;
			res_valid  <= 1'b0;
			grad_x     <= '0;
			grad_y     <= '0;
			magnitude  <= '0;
			frame_last <= 1'b0;
		end else begin
			// the emit state sets the slot itself
			if (res_valid && res_ready && (state_q != ST_EMIT)) begin
				res_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (px_acc) begin
						if (start_frame) begin
							fw_q   <= fw_new;
							fh_q   <= fh_new;
							lead_q <= lead_new;
						end
						if (push) begin
							in_pos_q  <= in_pos_q + POS_W'(1);
							in_addr_q <= (in_addr_q == AW'(DEPTH - 1)) ? '0 : in_addr_q + AW'(1);
							if (col_wrap) begin
								in_col_q <= '0;
								in_row_q <= in_row_q + FH_W'(1);
							end else begin
								in_col_q <= COL_W'(col_inc);
							end
						end
						if (gen) begin
							state_q <= ST_BLUR;
						end
					end
				end
				ST_BLUR: begin
					if (blur_done) begin
						state_q <= ST_SOBEL;
					end
				end
				ST_SOBEL: begin
					gx_q    <= gx_c;
					gy_q    <= gy_c;
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_valid  <= 1'b1;
						grad_x     <= gx_q;
						grad_y     <= gy_q;
						magnitude  <= MAG_W'(root);
						frame_last <= frame_end;
						state_q    <= ST_IDLE;
						if (frame_end) begin
							in_pos_q   <= '0;
							in_col_q   <= '0;
							in_row_q   <= '0;
							in_addr_q  <= '0;
							out_col_q  <= '0;
							out_row_q  <= '0;
							out_addr_q <= '0;
						end else begin
							out_addr_q <= (out_addr_q == AW'(DEPTH - 1)) ? '0
								: out_addr_q + AW'(1);
							if (ocol_wrap) begin
								out_col_q <= '0;
								out_row_q <= ROW_W'(orow_next);
							end else begin
								out_col_q <= COL_W'(ocol_inc);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no tap reads in flight while a new item can be taken
	a_idle_no_taps: assert property (@(posedge clk) disable iff (!arst_n)
		px_ready |-> !tap_busy)
		else $error("tap reads in flight while accepting an item");

	// output column stays inside the frame
	a_out_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		px_ready |-> (FW_W'(out_col_q) < fw_q))
		else $error("output column beyond frame width");

	// root completes only while waiting for it
	a_root_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> (state_q == ST_ROOT))
		else $error("square root finished outside its wait state");

	// end of frame returns all counters to zero
	a_frame_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && slot_free && frame_end) |=>
		(in_pos_q == '0 && out_row_q == '0 && out_col_q == '0 && frame_last))
		else $error("frame end did not clear counters");

endmodule
